FILE: rtl/bfmd_pkg.sv
// ----------------------------------------------------------------------------
// Box filter mip downsampler package
// Shared widths, register indexes, payload types and reset values.
// ----------------------------------------------------------------------------
package bfmd_pkg;

   localparam int CHAN_W        = 8;
   localparam int NUM_CHAN      = 4;
   localparam int PAIR_W        = CHAN_W + 1;
   localparam int OUT_WIDTH_W   = 12;
   localparam int CHAN_COUNT_W  = 3;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 12;

   localparam int DEF_MAX_OUT_WIDTH = 2048;
   localparam int MAX_CHANNELS      = 4;

   localparam logic [OUT_WIDTH_W-1:0]  OUT_WIDTH_RESET  = OUT_WIDTH_W'(256);
   localparam logic [CHAN_COUNT_W-1:0] CHAN_COUNT_RESET = CHAN_COUNT_W'(4);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OUTPUT_WIDTH  = 2'd0,
      CSR_CHANNEL_COUNT = 2'd1
   } csr_index_type;

   typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel4_type;
   typedef logic [NUM_CHAN-1:0][PAIR_W-1:0] sum4_type;

endpackage

FILE: rtl/bfmd_if.sv
// ----------------------------------------------------------------------------
// Box filter mip downsampler channel interfaces
// Source pixel, result pixel and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface bfmd_req_if;
   logic                         valid;
   logic                         ready;
   logic                         start_of_image;
   logic [bfmd_pkg::CHAN_W-1:0]  pixel_ch0;
   logic [bfmd_pkg::CHAN_W-1:0]  pixel_ch1;
   logic [bfmd_pkg::CHAN_W-1:0]  pixel_ch2;
   logic [bfmd_pkg::CHAN_W-1:0]  pixel_ch3;

   modport source (output valid, start_of_image, pixel_ch0, pixel_ch1, pixel_ch2,
                   pixel_ch3, input ready);
   modport sink   (input valid, start_of_image, pixel_ch0, pixel_ch1, pixel_ch2,
                   pixel_ch3, output ready);
endinterface

interface bfmd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bfmd_pkg::CHAN_W-1:0]  mip_ch0;
   logic [bfmd_pkg::CHAN_W-1:0]  mip_ch1;
   logic [bfmd_pkg::CHAN_W-1:0]  mip_ch2;
   logic [bfmd_pkg::CHAN_W-1:0]  mip_ch3;

   modport source (output valid, mip_ch0, mip_ch1, mip_ch2, mip_ch3, input ready);
   modport sink   (input valid, mip_ch0, mip_ch1, mip_ch2, mip_ch3, output ready);
endinterface

interface bfmd_csr_if;
   logic                              valid;
   logic                              ready;
   logic [bfmd_pkg::CSR_INDEX_W-1:0]  index;
   logic [bfmd_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/box_filter_mip_downsampler.sv
// Pipeline: the source word that completes a 2x2 square starts a line buffer
// read into stage one; its result word then moves to the output register.
// Throughput: one source word per cycle unless a read result is stalled; the
// line buffer has one write and one read port, at most one used per word.
// Reset: counters, row flag, held pixel, pipeline valids and registers go to
// their defaults; the line buffer is not cleared (it is written before read).
// ----------------------------------------------------------------------------
// Box filter mip downsampler
// Averages each 2x2 square of a raster pixel stream into the next mip level,
// keeping horizontal pair sums of even rows in a single-port line buffer.
// ----------------------------------------------------------------------------
module box_filter_mip_downsampler #(
   parameter int MAX_OUT_WIDTH = bfmd_pkg::DEF_MAX_OUT_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   bfmd_req_if.sink         req,
   bfmd_rsp_if.source       rsp,
   bfmd_csr_if.sink         csr
);

   // Source column counter covers two source pixels per output pixel.
   localparam int COL_W = $clog2(2 * MAX_OUT_WIDTH);
   localparam int IDX_W = $clog2(MAX_OUT_WIDTH);
   localparam int CMP_W = (COL_W + 1 > bfmd_pkg::OUT_WIDTH_W + 1) ?
                          COL_W + 1 : bfmd_pkg::OUT_WIDTH_W + 1;
   localparam int NC    = bfmd_pkg::NUM_CHAN;

   // ------------------------------------------------------------------------
   // Configuration registers. Writes are always taken.
   // ------------------------------------------------------------------------
   logic [bfmd_pkg::OUT_WIDTH_W-1:0]  out_width_ff;
   logic [bfmd_pkg::CHAN_COUNT_W-1:0] chan_count_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_width_ff  <= bfmd_pkg::OUT_WIDTH_RESET;
         chan_count_ff <= bfmd_pkg::CHAN_COUNT_RESET;
      end else if (csr.valid) begin
         unique case (csr.index)
            bfmd_pkg::CSR_OUTPUT_WIDTH:
               out_width_ff <= csr.data[bfmd_pkg::OUT_WIDTH_W-1:0];
            bfmd_pkg::CSR_CHANNEL_COUNT:
               chan_count_ff <= csr.data[bfmd_pkg::CHAN_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Effective width and channel mask. A width of zero acts as one and a
   // width beyond the line buffer is clamped to its depth; the channel count
   // is clamped the same way.
   // ------------------------------------------------------------------------
   logic [CMP_W-1:0] width_ext;
   logic [CMP_W-1:0] eff_width;
   logic [COL_W-1:0] last_col;
   logic [bfmd_pkg::CHAN_COUNT_W-1:0] eff_chans;
   logic [NC-1:0]    chan_mask;

   always_comb begin
      width_ext = CMP_W'(out_width_ff);
      if (width_ext == '0) begin
         eff_width = CMP_W'(1);
      end else if (width_ext > CMP_W'(MAX_OUT_WIDTH)) begin
         eff_width = CMP_W'(MAX_OUT_WIDTH);
      end else begin
         eff_width = width_ext;
      end
      last_col = COL_W'((eff_width << 1) - CMP_W'(1));

      if (chan_count_ff == '0) begin
         eff_chans = bfmd_pkg::CHAN_COUNT_W'(1);
      end else if (chan_count_ff > bfmd_pkg::CHAN_COUNT_W'(bfmd_pkg::MAX_CHANNELS)) begin
         eff_chans = bfmd_pkg::CHAN_COUNT_W'(bfmd_pkg::MAX_CHANNELS);
      end else begin
         eff_chans = chan_count_ff;
      end
      for (int i = 0; i < NC; i++) begin
         chan_mask[i] = (bfmd_pkg::CHAN_COUNT_W'(i) < eff_chans);
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline control. Stage one holds a pending line buffer read; the output
   // register holds a finished word. Both advance together whenever the
   // output register is free or being emptied, so input is only held off
   // when a read result cannot move on.
   // ------------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance;
   logic accept;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = !s1_valid_ff || advance;
   assign accept    = req.valid && req.ready;

   // ------------------------------------------------------------------------
   // Stage zero: position in the image, pair sum, line buffer access.
   // ------------------------------------------------------------------------
   logic [COL_W-1:0] col_ff, col_in;
   logic             odd_row_ff, odd_row_in;
   logic [COL_W-1:0] col_start;
   logic             odd_row_start;
   logic [COL_W-1:0] col_cur;
   logic [IDX_W-1:0] line_idx;
   bfmd_pkg::pixel4_type px;
   bfmd_pkg::pixel4_type left_ff, left_in;
   bfmd_pkg::sum4_type   pair_sum;
   logic             line_wr;
   logic             line_rd;

   always_comb begin
      // Start of image restarts the counters before this pixel is placed.
      col_start     = req.start_of_image ? '0 : col_ff;
      odd_row_start = req.start_of_image ? 1'b0 : odd_row_ff;
      // A column past a shrunken row end is treated as the row's last pixel.
      col_cur  = (col_start > last_col) ? last_col : col_start;
      line_idx = col_cur[COL_W-1:1];

      px[0] = chan_mask[0] ? req.pixel_ch0 : '0;
      px[1] = chan_mask[1] ? req.pixel_ch1 : '0;
      px[2] = chan_mask[2] ? req.pixel_ch2 : '0;
      px[3] = chan_mask[3] ? req.pixel_ch3 : '0;

      for (int i = 0; i < NC; i++) begin
         pair_sum[i] = bfmd_pkg::PAIR_W'(left_ff[i]) + bfmd_pkg::PAIR_W'(px[i]);
      end

      line_wr = accept && col_cur[0] && !odd_row_start;
      line_rd = accept && col_cur[0] &&  odd_row_start;

      left_in    = left_ff;
      col_in     = col_ff;
      odd_row_in = odd_row_ff;
      if (accept) begin
         if (!col_cur[0]) begin
            left_in = px;
         end
         if (col_cur >= last_col) begin
            col_in     = '0;
            odd_row_in = !odd_row_start;
         end else begin
            col_in     = col_cur + COL_W'(1);
            odd_row_in = odd_row_start;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         odd_row_ff <= 1'b0;
         left_ff    <= '0;
      end else begin
         col_ff     <= col_in;
         odd_row_ff <= odd_row_in;
         left_ff    <= left_in;
      end
   end

   // ------------------------------------------------------------------------
   // Line buffer of pair sums. Writes come from even rows and reads from odd
   // rows at odd columns; the word after any write has an even column, so a
   // read never meets a write to the same entry in the same or next cycle
   // and no forwarding is needed.
   // ------------------------------------------------------------------------
   bfmd_pkg::sum4_type line_mem [MAX_OUT_WIDTH];
   bfmd_pkg::sum4_type line_rdata_ff;

   always_ff @(posedge clock) begin
      if (line_wr) begin
         line_mem[line_idx] <= pair_sum;
      end
      if (line_rd) begin
         line_rdata_ff <= line_mem[line_idx];
      end
   end

   // ------------------------------------------------------------------------
   // Stage one: the current pair sum and channel mask wait for the read data.
   // ------------------------------------------------------------------------
   bfmd_pkg::sum4_type s1_sum_ff, s1_sum_in;
   logic [NC-1:0]      s1_mask_ff, s1_mask_in;
   bfmd_pkg::pixel4_type mip_ff, mip_in;
   logic [bfmd_pkg::PAIR_W:0] quad_sum;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_sum_in   = s1_sum_ff;
      s1_mask_in  = s1_mask_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (line_rd) begin
         s1_valid_in = 1'b1;
         s1_sum_in   = pair_sum;
         s1_mask_in  = chan_mask;
      end

      // Output register: sum of four values divided by four, truncated.
      rsp_valid_in = rsp_valid_ff;
      mip_in       = mip_ff;
      quad_sum     = '0;
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
         for (int i = 0; i < NC; i++) begin
            quad_sum  = (bfmd_pkg::PAIR_W + 1)'(line_rdata_ff[i]) +
                        (bfmd_pkg::PAIR_W + 1)'(s1_sum_ff[i]);
            mip_in[i] = s1_mask_ff[i] ? quad_sum[bfmd_pkg::PAIR_W:2] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_sum_ff  <= s1_sum_in;
      s1_mask_ff <= s1_mask_in;
      mip_ff     <= mip_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.mip_ch0 = mip_ff[0];
   assign rsp.mip_ch1 = mip_ff[1];
   assign rsp.mip_ch2 = mip_ff[2];
   assign rsp.mip_ch3 = mip_ff[3];

endmodule
